FILE: src/cis_pkg.sv
package cis_pkg;

    // Number of ids the set can hold.
    localparam int CAPACITY = 128;

    // Widths of the store address and of the fill count.
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Fixed field widths of the channels.
    localparam int ID_W        = 32;
    localparam int INDEX_W     = 7;
    localparam int COUNT_OUT_W = 8;

    // Width used to compare a read index against the count.
    localparam int CMP_W = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

    // Request kinds.
    typedef enum logic [1:0] {
        REQ_ADD  = 2'd0,
        REQ_DEL  = 2'd1,
        REQ_FIND = 2'd2,
        REQ_READ = 2'd3
    } req_kind_t;

    // One input item.
    typedef struct packed {
        logic [1:0]         req_type;
        logic [ID_W-1:0]    id;
        logic [INDEX_W-1:0] index;
    } cis_req_t;

    // One result item.
    typedef struct packed {
        logic                   success;
        logic [ID_W-1:0]        id_out;
        logic [COUNT_OUT_W-1:0] count;
    } cis_rsp_t;

endpackage

FILE: src/cis_ram.sv
module cis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/compacting_id_set_top.sv
// A rejected request goes straight to the done state; a read fetches its entry first; an add or a find
// scans the store from the bottom, and a delete scans, then shifts every entry above the match down.
// One item at a time: s_ready is high only in the idle state, and the single read port of the id store
// is scanned one entry per cycle.
// Reset (aresetn low, synchronous) empties the set and sets reserved_id to all ones; the
// store itself is not cleared, as no entry is read at or above the count.
module compacting_id_set_top (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [31:0]              cfg_wr_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  cis_pkg::cis_req_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output cis_pkg::cis_rsp_t        m_data
);

    import cis_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    cis_req_t          req_reg, req_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ID_W-1:0]   reserved_reg, reserved_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [CNT_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              res_success_reg, res_success_next;
    logic [ID_W-1:0]   res_id_reg, res_id_next;
    logic              m_valid_reg, m_valid_next;
    cis_rsp_t          m_data_reg, m_data_next;

    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [ID_W-1:0]   ram_wr_data;
    logic              ram_rd_en;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [ID_W-1:0]   ram_rd_data;

    logic              issue_more;
    logic              hit;

    // Id store, kept dense below the count.
    cis_ram #(
        .WIDTH(ID_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_data     = m_data_reg;
    assign issue_more = (issue_reg < count_reg);
    assign hit        = cmp_valid_reg && (ram_rd_data == req_reg.id);

    // Sequencer: scan the store for a match, then append, report or shift down.
    always_comb begin
        state_next       = state_reg;
        req_next         = req_reg;
        count_next       = count_reg;
        reserved_next    = reserved_reg;
        issue_next       = issue_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        res_success_next = res_success_reg;
        res_id_next      = res_id_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;
        ram_rd_en        = 1'b0;
        ram_rd_addr      = issue_reg[ADDR_W-1:0];
        ram_wr_en        = 1'b0;
        ram_wr_addr      = cmp_idx_reg[ADDR_W-1:0];
        ram_wr_data      = ram_rd_data;

        // The output register empties when its item is taken.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // Register write.
        if (cfg_wr_en) begin
            reserved_next = cfg_wr_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next         = s_data;
                    issue_next       = '0;
                    cmp_valid_next   = 1'b0;
                    res_success_next = 1'b0;
                    res_id_next      = reserved_reg;
                    if (s_data.req_type == REQ_READ) begin
                        if (CMP_W'(s_data.index) < CMP_W'(count_reg)) begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = ADDR_W'(s_data.index);
                            state_next  = ST_FETCH;
                        end else begin
                            state_next = ST_DONE;
                        end
                    end else if (s_data.id == reserved_reg) begin
                        state_next = ST_DONE;
                    end else if ((s_data.req_type == REQ_ADD) &&
                                 (count_reg == CNT_W'(CAPACITY))) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_FETCH: begin
                res_success_next = 1'b1;
                res_id_next      = ram_rd_data;
                state_next       = ST_DONE;
            end

            ST_SCAN: begin
                if (hit) begin
                    // The id is present at cmp_idx_reg.
                    case (req_reg.req_type)
                        REQ_FIND: begin
                            res_success_next = 1'b1;
                            state_next       = ST_DONE;
                        end
                        REQ_DEL: begin
                            issue_next     = cmp_idx_reg + CNT_W'(1);
                            cmp_valid_next = 1'b0;
                            state_next     = ST_SHIFT;
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end else if (issue_more) begin
                    ram_rd_en      = 1'b1;
                    issue_next     = issue_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg;
                end else begin
                    // Every entry compared without a match.
                    if (req_reg.req_type == REQ_ADD) begin
                        ram_wr_en        = 1'b1;
                        ram_wr_addr      = count_reg[ADDR_W-1:0];
                        ram_wr_data      = req_reg.id;
                        count_next       = count_reg + CNT_W'(1);
                        res_success_next = 1'b1;
                    end
                    state_next = ST_DONE;
                end
            end

            ST_SHIFT: begin
                // Each entry read is written one place lower in the next cycle, as its data arrives.
                if (cmp_valid_reg) begin
                    ram_wr_en = 1'b1;
                end
                if (issue_more) begin
                    ram_rd_en      = 1'b1;
                    issue_next     = issue_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = issue_reg - CNT_W'(1);
                end else begin
                    cmp_valid_next = 1'b0;
                    if (!cmp_valid_reg) begin
                        count_next       = count_reg - CNT_W'(1);
                        res_success_next = 1'b1;
                        state_next       = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_data_next.success = res_success_reg;
                    m_data_next.id_out  = res_id_reg;
                    m_data_next.count   = COUNT_OUT_W'(count_reg);
                    state_next          = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            reserved_reg  <= '1;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            reserved_reg  <= reserved_next;
            cmp_valid_reg <= cmp_valid_next;
            m_valid_reg   <= m_valid_next;
        end
        req_reg         <= req_next;
        issue_reg       <= issue_next;
        cmp_idx_reg     <= cmp_idx_next;
        res_success_reg <= res_success_next;
        res_id_reg      <= res_id_next;
        m_data_reg      <= m_data_next;
    end

endmodule

FILE: tb/compacting_id_set_checker.sv
// Scoreboard for the id set: it follows the request channel, predicts each
// result from its own copy of the set, and compares the result channel with it.
module compacting_id_set_checker
    import cis_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  cis_req_t   s_data,
    input  logic       m_valid,
    input  logic       m_ready,
    input  cis_rsp_t   m_data,
    output int         fail_count,
    output int         pending_count
);

    // Shadow copy of the set and of the reserved id.
    logic [ID_W-1:0] shadow_ids [CAPACITY];
    int              shadow_count;
    logic [ID_W-1:0] shadow_reserved;

    // Results still owed by the block, oldest first.
    cis_rsp_t owed_results [$];

    // Applies one request to the shadow set and returns the result it must give.
    function automatic cis_rsp_t apply_request(input cis_req_t req);
        cis_rsp_t rsp;
        int       pos;
        rsp.success = 1'b0;
        rsp.id_out  = shadow_reserved;
        pos = -1;
        for (int i = 0; i < shadow_count; i++) begin
            if (pos < 0 && shadow_ids[i] == req.id) begin
                pos = i;
            end
        end
        case (req_kind_t'(req.req_type))
            REQ_ADD: begin
                if (req.id != shadow_reserved && shadow_count < CAPACITY && pos < 0) begin
                    shadow_ids[shadow_count] = req.id;
                    shadow_count++;
                    rsp.success = 1'b1;
                end
            end
            REQ_DEL: begin
                // Close the gap so the live entries stay packed at the bottom.
                if (req.id != shadow_reserved && pos >= 0) begin
                    for (int j = pos; j < shadow_count - 1; j++) begin
                        shadow_ids[j] = shadow_ids[j + 1];
                    end
                    shadow_count--;
                    rsp.success = 1'b1;
                end
            end
            REQ_FIND: begin
                if (req.id != shadow_reserved && pos >= 0) begin
                    rsp.success = 1'b1;
                end
            end
            default: begin
                if (int'(req.index) < shadow_count) begin
                    rsp.id_out  = shadow_ids[req.index];
                    rsp.success = 1'b1;
                end
            end
        endcase
        rsp.count = COUNT_OUT_W'(shadow_count);
        return rsp;
    endfunction

    // Everything is sampled at the rising edge, where the driven inputs are stable.
    always @(posedge aclk) begin
        cis_rsp_t want;
        if (!aresetn) begin
            shadow_count    = 0;
            shadow_reserved = '1;
            owed_results.delete();
        end else begin
            if (cfg_wr_en) begin
                shadow_reserved = cfg_wr_data;
            end
            // Compare a delivered result with the oldest one owed.
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    $error("result item with no request waiting: success=%0d id_out=%h count=%0d",
                           m_data.success, m_data.id_out, m_data.count);
                    fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_data.success !== want.success) begin
                        $error("success: expected %0d, got %0d", want.success, m_data.success);
                        fail_count++;
                    end
                    if (m_data.id_out !== want.id_out) begin
                        $error("id_out: expected %h, got %h", want.id_out, m_data.id_out);
                        fail_count++;
                    end
                    if (m_data.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, m_data.count);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                owed_results.push_back(apply_request(s_data));
            end
        end
        pending_count = owed_results.size();
    end

endmodule

FILE: tb/tb_compacting_id_set_top.sv
module tb_compacting_id_set_top;
    import cis_pkg::*;

    localparam int POOL_SIZE   = 160;
    localparam int ITEM_TARGET = 1250;
    localparam int MAX_GAP     = 13;
    // Longest single request is a delete in a full set.
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 8;
    localparam int RUN_LIMIT     = 6000000;

    logic       aclk;
    logic       aresetn;
    logic       cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic       s_valid;
    logic       s_ready;
    cis_req_t   s_data;
    logic       m_valid;
    logic       m_ready;
    cis_rsp_t   m_data;

    int fail_count;
    int pending_count;
    int items_sent;

    logic [ID_W-1:0] id_pool [POOL_SIZE];
    logic [ID_W-1:0] cur_reserved;
    bit              sender_no_gap;
    bit              receiver_no_stall;

    compacting_id_set_top u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    compacting_id_set_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
    end

    always #2 aclk = ~aclk;

    // Hard stop in case the block hangs.
    initial begin
        #RUN_LIMIT;
        $display("tb_compacting_id_set_top: done, errors");
        $finish;
    end

    function automatic cis_req_t build_request(input req_kind_t kind, input logic [ID_W-1:0] id,
                                               input logic [INDEX_W-1:0] index);
        cis_req_t req;
        req.req_type = kind;
        req.id       = id;
        req.index    = index;
        return req;
    endfunction

    // Mostly ids from the pool so that adds, finds and deletes hit each other.
    function automatic logic [ID_W-1:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) begin
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (roll < 92) begin
            return $urandom;
        end
        return cur_reserved;
    endfunction

    // Read indexes lean toward the filled region and the top of the store.
    function automatic logic [INDEX_W-1:0] pick_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return INDEX_W'($urandom_range(0, 20));
        end else if (roll < 80) begin
            return INDEX_W'($urandom_range(100, 127));
        end
        return INDEX_W'($urandom_range(0, 127));
    endfunction

    // Offers one item after a random gap and returns at the falling edge after it
    // was taken; valid is left high so a back-to-back item needs no extra edge.
    task automatic send_item(input cis_req_t req);
        int gap;
        gap = sender_no_gap ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_data  <= req;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        @(negedge aclk);
        items_sent++;
    endtask

    // Drops valid, lets every owed result drain, then writes the reserved id.
    task automatic write_reserved(input logic [ID_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        cur_reserved = value;
    endtask

    // Result side: a random stall before each item, with stall-free stretches.
    initial begin
        int stall;
        int taken;
        m_ready = 1'b0;
        taken   = 0;
        @(negedge aclk);
        forever begin
            if (taken % 64 == 0) begin
                receiver_no_stall = ($urandom_range(0, 3) == 0);
            end
            stall = receiver_no_stall ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
            @(negedge aclk);
            taken++;
        end
    end

    // Request side and verdict.
    initial begin
        int        roll;
        int        start;
        bit        first_phase;
        req_kind_t kind;

        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_data        = build_request(REQ_READ, '0, '0);
        items_sent    = 0;
        cur_reserved  = '1;
        sender_no_gap = 1'b0;
        // Distinct pool entries: the low byte is the slot number.
        for (int i = 0; i < POOL_SIZE; i++) begin
            id_pool[i] = ($urandom & 32'hFFFF_FF00) | i;
        end
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Empty set, duplicates, reserved id and the id extremes.
        send_item(build_request(REQ_READ, 32'h0, 7'd0));
        send_item(build_request(REQ_DEL, 32'h5, 7'd0));
        send_item(build_request(REQ_ADD, 32'h0, 7'd0));
        send_item(build_request(REQ_ADD, 32'h0, 7'd0));
        send_item(build_request(REQ_ADD, 32'hFFFF_FFFF, 7'd0));
        send_item(build_request(REQ_ADD, 32'h7FFF_FFFF, 7'd127));
        send_item(build_request(REQ_ADD, 32'h8000_0000, 7'd0));
        send_item(build_request(REQ_ADD, 32'h1234_5678, 7'd0));
        send_item(build_request(REQ_FIND, 32'h0, 7'd0));
        send_item(build_request(REQ_FIND, 32'h8000_0000, 7'd0));
        send_item(build_request(REQ_FIND, 32'h5, 7'd0));
        send_item(build_request(REQ_FIND, 32'hFFFF_FFFF, 7'd0));
        send_item(build_request(REQ_READ, 32'h0, 7'd1));
        send_item(build_request(REQ_READ, 32'h0, 7'd4));
        send_item(build_request(REQ_READ, 32'hFFFF_FFFF, 7'd127));
        send_item(build_request(REQ_DEL, 32'hFFFF_FFFF, 7'd0));
        // Delete from the middle, then check the shifted entry.
        send_item(build_request(REQ_DEL, 32'h7FFF_FFFF, 7'd0));
        send_item(build_request(REQ_READ, 32'h0, 7'd1));
        send_item(build_request(REQ_DEL, 32'h1234_5678, 7'd0));

        // A stored id becomes the reserved id: it is hidden from find and
        // delete but still readable, while the old reserved value is now usable.
        write_reserved(32'h8000_0000);
        send_item(build_request(REQ_FIND, 32'h8000_0000, 7'd0));
        send_item(build_request(REQ_DEL, 32'h8000_0000, 7'd0));
        send_item(build_request(REQ_READ, 32'h0, 7'd1));
        send_item(build_request(REQ_ADD, 32'hFFFF_FFFF, 7'd0));
        write_reserved(32'h0);
        send_item(build_request(REQ_READ, 32'h0, 7'd0));
        send_item(build_request(REQ_ADD, 32'h0, 7'd0));

        // Random phases; the first one fills the set to capacity.
        first_phase = 1'b1;
        while (items_sent < ITEM_TARGET) begin
            if (!first_phase && $urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_reserved(32'hFFFF_FFFF);
                    1: write_reserved(32'h0);
                    2: write_reserved(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
                    default: write_reserved($urandom);
                endcase
            end
            sender_no_gap = ($urandom_range(0, 3) == 0);
            roll = first_phase ? 5 : $urandom_range(0, 9);
            first_phase = 1'b0;
            start = $urandom_range(0, POOL_SIZE - 1);
            if (roll < 5) begin
                // Mixed traffic over the pool.
                repeat (60) begin
                    roll = $urandom_range(0, 99);
                    kind = (roll < 35) ? REQ_ADD : (roll < 60) ? REQ_DEL :
                           (roll < 80) ? REQ_FIND : REQ_READ;
                    send_item(build_request(kind, pick_id(), pick_index()));
                end
            end else if (roll < 7) begin
                // Walk the pool with adds until the set is full and adds bounce.
                for (int i = 0; i < 140; i++) begin
                    send_item(build_request(REQ_ADD, id_pool[(start + i) % POOL_SIZE],
                                            pick_index()));
                    if ($urandom_range(0, 9) == 0) begin
                        send_item(build_request(REQ_READ, pick_id(), pick_index()));
                    end
                end
                send_item(build_request(REQ_READ, pick_id(), 7'd127));
            end else if (roll < 9) begin
                // Walk the pool with deletes and some finds, which drains the set.
                for (int i = 0; i < 140; i++) begin
                    kind = ($urandom_range(0, 4) == 0) ? REQ_FIND : REQ_DEL;
                    send_item(build_request(kind, id_pool[(start + i) % POOL_SIZE],
                                            pick_index()));
                end
            end else begin
                // Unbiased noise.
                repeat (30) begin
                    kind = req_kind_t'($urandom_range(0, 3));
                    send_item(build_request(kind, $urandom,
                                            INDEX_W'($urandom_range(0, 127))));
                end
            end
        end

        // Let every owed result come back, then watch for stray ones.
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (fail_count == 0) begin
            $display("tb_compacting_id_set_top: done, clean");
        end else begin
            $display("tb_compacting_id_set_top: done, errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/cis_pkg.sv
src/cis_ram.sv
src/compacting_id_set_top.sv
tb/compacting_id_set_checker.sv
tb/tb_compacting_id_set_top.sv
